### rtl/nrp_pkg.sv
// Package for the nested region profiler: item types, region constants and
// status/function codes. No dependencies.
package nrp_pkg;

  localparam int REGION_W     = 12;
  localparam int REGION_COUNT = 1 << REGION_W;

  typedef enum logic [1:0] {
    FUNC_ENTER = 2'd0,
    FUNC_EXIT  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_PAR_UPD,
    S_REG_RD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]          func;
    logic [REGION_W-1:0] region;
    logic [63:0]         timestamp;
  } in_item_t;

  typedef struct packed {
    logic [63:0] enter_count;
    logic [63:0] exclusive_time;
    logic [63:0] inclusive_time;
    logic [1:0]  status;
  } out_item_t;

endpackage

### rtl/nested_region_profiler.sv
// Top level of the nested region profiler: counter memory, nesting stack
// memory and the sequencer. Depends on nrp_pkg.
//
// Channel  Dir  Handshake          Payload
// in       in   start_i & !busy_o  in_i   (func, region, timestamp)
// out      out  done_o strobe      out_o  (counters, status)
//
// Enter, read, full-stack and empty-stack items pass through LOOKUP and DONE before
// the result transfer; an exit that pops a frame also passes through PAR_UPD and
// REG_RD, since the parent update, the region read and the region update share one
// counter memory port. busy_o is low in the cycle that shows done_o, so the next
// item can be taken then. After reset a clearing pass writes every region entry
// while busy_o stays high. The receiver cannot stall; done_o lasts one cycle.
module nested_region_profiler #(
  parameter int STACK_DEPTH  = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  nrp_pkg::in_item_t in_i,
  output logic              busy_o,
  output logic              done_o,
  output nrp_pkg::out_item_t out_o
);
  import nrp_pkg::*;

  localparam int RW = REGION_W;
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);

  // One word holds hit, exclusive and inclusive counters of a region.
  typedef struct packed {
    logic [63:0] hit;
    logic [63:0] excl;
    logic [63:0] incl;
  } cnt_t;

  typedef struct packed {
    logic [RW-1:0] reg_idx;
    logic [RW-1:0] par_idx;
    logic [63:0]   old_incl;
    logic [63:0]   start;
  } frame_t;

  cnt_t   cnt_mem [REGION_COUNT];
  frame_t stk_mem [STACK_DEPTH];

  state_e state_q, state_d;
  logic [RW-1:0] clr_q;
  logic [LW-1:0] level_q;
  logic [RW-1:0] cur_q;
  in_item_t      item_q;
  logic [RW-1:0] ridx;
  cnt_t          rdata_q;
  frame_t        sdata_q;
  out_item_t     out_q;
  out_item_t     out_d;
  logic          done_q;

  logic          c_we;
  logic [RW-1:0] c_addr;
  cnt_t          c_wdata;
  logic          s_we;
  logic [SW-1:0] s_addr;
  frame_t        s_wdata;

  logic is_enter, is_exit, full, empty, same, pop;
  logic [63:0] elapsed;
  logic [SW-1:0] top;
  cnt_t par_upd, reg_upd, hit_upd;

  assign ridx     = in_i.region;
  assign is_enter = (item_q.func == FUNC_ENTER);
  assign is_exit  = (item_q.func == FUNC_EXIT);
  assign full     = (level_q == LW'(STACK_DEPTH));
  assign empty    = (level_q == '0);
  assign pop      = is_exit && !empty;
  assign top      = SW'(level_q - LW'(1));
  assign same     = (sdata_q.reg_idx == sdata_q.par_idx);
  assign elapsed  = item_q.timestamp - sdata_q.start;

  always_ff @(posedge clk_i) begin
    if (c_we) cnt_mem[c_addr] <= c_wdata;
    rdata_q <= cnt_mem[c_addr];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) stk_mem[s_addr] <= s_wdata;
    sdata_q <= stk_mem[s_addr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (clr_q == RW'(REGION_COUNT - 1)) state_d = S_IDLE;
      S_IDLE:    if (start_i) state_d = S_LOOKUP;
      S_LOOKUP:  state_d = pop ? S_PAR_UPD : S_DONE;
      S_PAR_UPD: state_d = S_REG_RD;
      S_REG_RD:  state_d = S_DONE;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Counter words after each kind of update; a region that is its own parent
  // keeps its times.
  always_comb begin
    par_upd      = rdata_q;
    par_upd.excl = rdata_q.excl - elapsed;
    hit_upd      = rdata_q;
    hit_upd.hit  = rdata_q.hit + 64'd1;
    reg_upd      = rdata_q;
    if (!same) begin
      reg_upd.excl = rdata_q.excl + elapsed;
      reg_upd.incl = sdata_q.old_incl + elapsed;
    end
  end

  // Memory port control. The top frame is read at the accepting edge. A popping
  // exit reads the parent in LOOKUP, writes it in PAR_UPD, reads the region in
  // REG_RD and writes it in DONE.
  always_comb begin
    c_we    = 1'b0;
    c_addr  = item_q.region;
    c_wdata = rdata_q;
    s_we    = 1'b0;
    s_addr  = top;
    s_wdata = '{reg_idx: item_q.region, par_idx: cur_q,
                old_incl: rdata_q.incl, start: item_q.timestamp};
    case (state_q)
      S_CLEAR: begin
        c_we    = 1'b1;
        c_addr  = clr_q;
        c_wdata = '0;
      end
      S_IDLE: begin
        c_addr = ridx;
      end
      S_LOOKUP: begin
        if (pop) c_addr = sdata_q.par_idx;
      end
      S_PAR_UPD: begin
        c_addr  = sdata_q.par_idx;
        c_we    = !same;
        c_wdata = par_upd;
      end
      S_REG_RD: begin
        c_addr = sdata_q.reg_idx;
      end
      S_DONE: begin
        if (pop) begin
          c_addr  = sdata_q.reg_idx;
          c_we    = !same;
          c_wdata = reg_upd;
        end else if (is_enter && !full) begin
          c_we    = 1'b1;
          c_wdata = hit_upd;
          s_we    = 1'b1;
          s_addr  = SW'(level_q);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d = '{enter_count: rdata_q.hit, exclusive_time: rdata_q.excl,
              inclusive_time: rdata_q.incl, status: ST_OK};
    if (is_enter) begin
      if (full) out_d.status = ST_FULL;
      else out_d.enter_count = hit_upd.hit;
    end else if (is_exit) begin
      if (empty) begin
        out_d = '{enter_count: '0, exclusive_time: '0, inclusive_time: '0,
                  status: ST_EMPTY};
      end else begin
        out_d = '{enter_count: reg_upd.hit, exclusive_time: reg_upd.excl,
                  inclusive_time: reg_upd.incl, status: ST_OK};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      level_q <= '0;
      cur_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_DONE);
      if (state_q == S_CLEAR) clr_q <= clr_q + RW'(1);
      if (state_q == S_DONE) begin
        if (is_enter && !full) begin
          level_q <= level_q + LW'(1);
          cur_q   <= item_q.region;
        end
        if (pop) begin
          level_q <= level_q - LW'(1);
          cur_q   <= sdata_q.par_idx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) item_q <= in_i;
    if (state_q == S_DONE) out_q <= out_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign out_o  = out_q;

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LW'(STACK_DEPTH)) else $error("stack level out of range");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(state_q == S_CLEAR)) else $error("result during clear");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done lasted two cycles");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE)) else $error("result while busy");
endmodule

### dv/tb_top.sv
// Testbench for the nested region profiler: directed and random enter, exit and
// read transfers checked against a behavioral profiler model. Depends on nrp_pkg.
module tb_top;
  import nrp_pkg::*;

  class profile_scoreboard;
    localparam int DEPTH = 64;

    logic [63:0] hits [REGION_COUNT];
    logic [63:0] excl [REGION_COUNT];
    logic [63:0] incl [REGION_COUNT];
    logic [11:0] frame_region [DEPTH];
    logic [11:0] frame_parent [DEPTH];
    logic [63:0] frame_old_incl [DEPTH];
    logic [63:0] frame_start [DEPTH];
    int level;
    logic [11:0] current;
    out_item_t pending_q[$];
    int errors;
    int checked;
    int enters, exits, reads, fulls, empties;

    function new();
      for (int i = 0; i < REGION_COUNT; i++) begin
        hits[i] = '0;
        excl[i] = '0;
        incl[i] = '0;
      end
      level = 0;
      current = '0;
      errors = 0;
      checked = 0;
      enters = 0; exits = 0; reads = 0; fulls = 0; empties = 0;
    endfunction

    function void note_item(in_item_t it);
      out_item_t res;
      logic [11:0] r;
      logic [11:0] p;
      logic [63:0] dt;
      r = it.region;
      res = '0;
      res.status = ST_OK;
      case (func_e'(it.func))
        FUNC_ENTER: begin
          if (level >= DEPTH) begin
            res.status = ST_FULL;
            fulls++;
          end else begin
            hits[r] = hits[r] + 64'd1;
            frame_region[level] = r;
            frame_parent[level] = current;
            frame_old_incl[level] = incl[r];
            frame_start[level] = it.timestamp;
            level++;
            current = r;
            enters++;
          end
        end
        FUNC_EXIT: begin
          if (level == 0) begin
            res.status = ST_EMPTY;
            empties++;
          end else begin
            level--;
            r = frame_region[level];
            p = frame_parent[level];
            dt = it.timestamp - frame_start[level];
            if (r != p) begin
              excl[p] = excl[p] - dt;
              excl[r] = excl[r] + dt;
              incl[r] = frame_old_incl[level] + dt;
            end
            current = p;
            exits++;
          end
        end
        default: reads++;
      endcase
      if (res.status != ST_EMPTY) begin
        res.enter_count = hits[r];
        res.exclusive_time = excl[r];
        res.inclusive_time = incl[r];
      end
      pending_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      checked++;
      if (got.enter_count !== exp.enter_count) begin
        $display("%0t: enter_count exp %h got %h", $time, exp.enter_count,
                 got.enter_count);
        errors++;
      end
      if (got.exclusive_time !== exp.exclusive_time) begin
        $display("%0t: exclusive_time exp %h got %h", $time, exp.exclusive_time,
                 got.exclusive_time);
        errors++;
      end
      if (got.inclusive_time !== exp.inclusive_time) begin
        $display("%0t: inclusive_time exp %h got %h", $time, exp.inclusive_time,
                 got.inclusive_time);
        errors++;
      end
      if (got.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start_i;
  in_item_t in_i;
  logic busy_o;
  logic done_o;
  out_item_t out_o;

  profile_scoreboard sb;
  logic [63:0] clock_count;
  bit quiet_mode;

  nested_region_profiler dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .in_i(in_i),
    .busy_o(busy_o), .done_o(done_o), .out_o(out_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(out_o);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Holds the item until the transfer happens and leaves start high; the next call
  // may lower it first for a random gap, and drain lowers it.
  task automatic send_item(func_e f, logic [11:0] r, logic [63:0] ts);
    int gap;
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= '{func: f, region: r, timestamp: ts};
    do @(posedge clk_i); while (busy_o);
    sb.note_item('{func: f, region: r, timestamp: ts});
    clock_count = ts;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_enter(logic [11:0] r);
    clock_count += 64'($urandom_range(1, 5000));
    send_item(FUNC_ENTER, r, clock_count);
  endtask

  task automatic send_exit();
    clock_count += 64'($urandom_range(1, 5000));
    send_item(FUNC_EXIT, 12'(rand64()), clock_count);
  endtask

  // Regions are mostly drawn from a small pool so counters accumulate.
  function automatic logic [11:0] pick_region();
    if ($urandom_range(0, 3) == 0) return 12'($urandom());
    return 12'($urandom_range(0, 15));
  endfunction

  initial begin
    logic [63:0] ts;
    int target;
    sb = new();
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_i = '0;
    clock_count = '0;
    quiet_mode = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty exit, extremes, wrap of elapsed time, self nesting.
    send_item(FUNC_EXIT, 12'hFFF, 64'd0);
    send_item(FUNC_READ, 12'h000, '1);
    send_item(FUNC_RSVD, 12'hFFF, 64'h5555_5555_AAAA_AAAA);
    send_item(FUNC_ENTER, 12'hFFF, '1);
    send_item(FUNC_ENTER, 12'h000, 64'd10);
    send_item(FUNC_ENTER, 12'h000, 64'd20);
    send_item(FUNC_EXIT, 12'h000, 64'd25);
    send_item(FUNC_EXIT, 12'hABC, 64'd40);
    send_item(FUNC_EXIT, 12'h000, 64'h8000_0000_0000_0000);
    send_item(FUNC_EXIT, 12'h000, 64'd0);
    send_item(FUNC_READ, 12'hFFF, 64'd0);
    send_item(FUNC_READ, 12'h000, 64'd0);
    drain();

    // Fill the stack past its depth, then unwind it past empty.
    for (int i = 0; i < 66; i++) send_enter(12'(i * 61));
    for (int i = 0; i < 66; i++) send_exit();
    drain();

    target = 1500;
    for (int n = 0; n < target; n++) begin
      if (n > target - 200) quiet_mode = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if (sb.level < 60 || $urandom_range(0, 7) == 0) send_enter(pick_region());
          else send_exit();
        end
        4, 5, 6: send_exit();
        7: send_item(FUNC_READ, pick_region(), rand64());
        8: send_item(FUNC_RSVD, pick_region(), rand64());
        default: begin
          ts = rand64();
          send_item(func_e'($urandom_range(0, 1)), 12'($urandom()), ts);
        end
      endcase
      if (n == target / 2) drain();
    end
    drain();

    $display("Covered %0d enters, %0d exits, %0d reads, %0d stack-full, %0d empty exits.",
             sb.enters, sb.exits, sb.reads, sb.fulls, sb.empties);
    $display("%0d results checked, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", sb.pending_q.size());
    $display("status: fail");
    $finish;
  end
endmodule
